[hdl/wad_pkg.sv]
// Shared types, constants and the sequencer program for the windowed average displacement block.
package wad_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int WCOUNT_W       = 6;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RST = 6'd2;
    localparam int COORD_W        = 32;
    localparam int DIST_W         = 32;
    localparam int SQRT_STEPS     = DIST_W;
    localparam int REM_W          = DIST_W + 3;
    localparam int STEP_W         = 5;
    localparam int CNT_W          = 7;

    // Request kinds carried on tuser.
    localparam logic CMD_POSITION = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef enum logic [4:0] {
        OP_WAIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT,
        OP_DIFF_X,
        OP_DIFF_Y,
        OP_SQ,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIST,
        OP_RD_HEAD,
        OP_DROP,
        OP_PUSH,
        OP_PREV
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_TICK,
        COND_NOT_SEEN,
        COND_LOOP,
        COND_OUT_BUSY,
        COND_NO_DROP
    } t_cond;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_DIV,
        CNT_SQRT
    } t_cnt;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        t_cnt               cnt;
        logic [STEP_W-1:0]  tgt;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic pos_load;
    } t_dp_ctl;

    typedef struct packed {
        logic seen;
        logic drop_needed;
        logic fill_zero;
    } t_dp_stat;

    localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] ST_AVG   = 5'd1;
    localparam logic [STEP_W-1:0] ST_DIV   = 5'd2;
    localparam logic [STEP_W-1:0] ST_EMIT  = 5'd3;
    localparam logic [STEP_W-1:0] ST_DIFFX = 5'd4;
    localparam logic [STEP_W-1:0] ST_SQRT  = 5'd11;
    localparam logic [STEP_W-1:0] ST_DIST  = 5'd12;
    localparam logic [STEP_W-1:0] ST_PUSH  = 5'd15;

    localparam int UCODE_LEN = 17;

    // One control word per step; a taken condition jumps to tgt, otherwise the step advances.
    localparam t_uword UCODE [UCODE_LEN] = '{
        '{OP_WAIT,      COND_NO_TICK,  CNT_KEEP, ST_IDLE},
        '{OP_DIV_INIT,  COND_NOT_SEEN, CNT_DIV,  ST_DIFFX},
        '{OP_DIV_STEP,  COND_LOOP,     CNT_KEEP, ST_DIV},
        '{OP_EMIT,      COND_OUT_BUSY, CNT_KEEP, ST_EMIT},
        '{OP_DIFF_X,    COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_SQ,        COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_ACC_LOAD,  COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_DIFF_Y,    COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_SQ,        COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_ACC_ADD,   COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_SQRT_INIT, COND_NEVER,    CNT_SQRT, ST_IDLE},
        '{OP_SQRT_STEP, COND_LOOP,     CNT_KEEP, ST_SQRT},
        '{OP_DIST,      COND_NO_DROP,  CNT_KEEP, ST_PUSH},
        '{OP_RD_HEAD,   COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_DROP,      COND_ALWAYS,   CNT_KEEP, ST_DIST},
        '{OP_PUSH,      COND_NEVER,    CNT_KEEP, ST_IDLE},
        '{OP_PREV,      COND_ALWAYS,   CNT_KEEP, ST_IDLE}
    };

endpackage

[hdl/wad_dpath.sv]
// Datapath: positions, distance ring, running sum, squarer and shared shift-subtract unit.
module wad_dpath #(
    parameter int WINDOW_MAX = wad_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wad_pkg::t_dp_ctl                     i_ctl,
    input  logic [wad_pkg::WCOUNT_W-1:0]         i_wcount,
    input  logic signed [wad_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [wad_pkg::COORD_W-1:0]   i_pos_y,
    output wad_pkg::t_dp_stat                    o_stat,
    output logic [wad_pkg::DIST_W-1:0]           o_res
);

    localparam int HW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW    = $clog2(WINDOW_MAX + 1);
    localparam int DW    = wad_pkg::DIST_W;
    localparam int CW    = wad_pkg::COORD_W;
    localparam int SUMW  = DW + $clog2(WINDOW_MAX);
    localparam int ACC_W = 2 * DW;
    localparam int REM_W = wad_pkg::REM_W;

    logic [DW-1:0]          r_mem [WINDOW_MAX];
    logic [DW-1:0]          r_rdata;
    logic [HW-1:0]          r_head;
    logic [FW-1:0]          r_fill;
    logic [SUMW-1:0]        r_sum;
    logic signed [CW-1:0]   r_cur_x;
    logic signed [CW-1:0]   r_cur_y;
    logic signed [CW-1:0]   r_prev_x;
    logic signed [CW-1:0]   r_prev_y;
    logic                   r_seen;

    logic [DW-1:0]          r_d;
    logic [ACC_W-1:0]       r_sq;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_sat;
    logic [REM_W-1:0]       r_rem;
    logic [DW-1:0]          r_res;
    logic [DW-1:0]          r_dist;

    logic [FW-1:0]          eff;
    logic [CW-1:0]          op_a;
    logic [CW-1:0]          op_b;
    logic [CW:0]            diff;
    logic [DW-1:0]          diff_abs;
    logic [REM_W-1:0]       rem_s;
    logic [REM_W-1:0]       trial;
    logic [REM_W-1:0]       rem_d;
    logic                   ge;
    logic [HW:0]            wsum;
    logic [HW-1:0]          waddr;
    logic [HW-1:0]          head_inc;
    logic                   push_en;

    assign eff = (int'(i_wcount) > WINDOW_MAX) ? FW'(WINDOW_MAX) : FW'(i_wcount);
    assign push_en = (i_ctl.op == wad_pkg::OP_PUSH) && (eff != '0);

    assign op_a     = (i_ctl.op == wad_pkg::OP_DIFF_Y) ? r_cur_y : r_cur_x;
    assign op_b     = (i_ctl.op == wad_pkg::OP_DIFF_Y) ? r_prev_y : r_prev_x;
    assign diff     = {op_a[CW-1], op_a} - {op_b[CW-1], op_b};
    assign diff_abs = diff[CW] ? DW'(-diff) : diff[DW-1:0];

    // Square root brings down two bits per step against 4*root+1; division one bit
    // per step against the fill count.
    always_comb begin
        if (i_ctl.op == wad_pkg::OP_SQRT_STEP) begin
            rem_s = {r_rem[REM_W-3:0], r_acc[ACC_W-1 -: 2]};
            trial = {1'b0, r_res, 2'b01};
        end else begin
            rem_s = {r_rem[REM_W-2:0], r_acc[ACC_W-1]};
            trial = REM_W'(r_fill);
        end
        ge    = (rem_s >= trial);
        rem_d = rem_s - trial;
    end

    assign wsum     = {1'b0, r_head} + (HW+1)'(r_fill);
    assign waddr    = (int'(wsum) >= WINDOW_MAX) ? HW'(int'(wsum) - WINDOW_MAX)
                                                 : wsum[HW-1:0];
    assign head_inc = (int'(r_head) == WINDOW_MAX - 1) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_seen   <= 1'b0;
        end else begin
            if (i_ctl.pos_load) begin
                r_cur_x <= i_pos_x;
                r_cur_y <= i_pos_y;
                if (!r_seen) begin
                    r_prev_x <= i_pos_x;
                    r_prev_y <= i_pos_y;
                    r_seen   <= 1'b1;
                end
            end
            case (i_ctl.op)
                wad_pkg::OP_DROP: begin
                    r_sum  <= r_sum - SUMW'(r_rdata);
                    r_head <= head_inc;
                    r_fill <= r_fill - 1'b1;
                end
                wad_pkg::OP_PUSH: begin
                    if (push_en) begin
                        r_sum  <= r_sum + SUMW'(r_dist);
                        r_fill <= r_fill + 1'b1;
                    end
                end
                wad_pkg::OP_PREV: begin
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            wad_pkg::OP_DIV_INIT: begin
                r_acc <= ACC_W'(r_sum) << (ACC_W - SUMW);
                r_rem <= '0;
                r_res <= '0;
            end
            wad_pkg::OP_DIV_STEP: begin
                r_acc <= r_acc << 1;
                r_rem <= ge ? rem_d : rem_s;
                r_res <= {r_res[DW-2:0], ge};
            end
            wad_pkg::OP_DIFF_X, wad_pkg::OP_DIFF_Y: begin
                r_d <= diff_abs;
            end
            wad_pkg::OP_SQ: begin
                r_sq <= r_d * r_d;
            end
            wad_pkg::OP_ACC_LOAD: begin
                r_acc <= r_sq;
                r_sat <= 1'b0;
            end
            wad_pkg::OP_ACC_ADD: begin
                {r_sat, r_acc} <= {1'b0, r_acc} + {1'b0, r_sq};
            end
            wad_pkg::OP_SQRT_INIT: begin
                r_rem <= '0;
                r_res <= '0;
            end
            wad_pkg::OP_SQRT_STEP: begin
                r_acc <= r_acc << 2;
                r_rem <= ge ? rem_d : rem_s;
                r_res <= {r_res[DW-2:0], ge};
            end
            wad_pkg::OP_DIST: begin
                r_dist <= r_sat ? '1 : r_res;
            end
            wad_pkg::OP_RD_HEAD: begin
                r_rdata <= r_mem[r_head];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[waddr] <= r_dist;
        end
    end

    always_comb begin
        o_stat.seen        = r_seen;
        o_stat.drop_needed = (r_fill != '0) && (r_fill >= eff);
        o_stat.fill_zero   = (r_fill == '0);
    end

    assign o_res = r_res;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= WINDOW_MAX)
        else $error("window fill exceeds window depth");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == wad_pkg::OP_DROP) |-> (r_fill != '0))
        else $error("drop issued on an empty window");

endmodule

[hdl/windowed_average_displacement.sv]
// Top level: stream ports, window count register, microcoded sequencer and result register.
//
//  Channel   Direction  Signals                         Content
//  s_axis    in         tvalid tready tdata[63:0] tuser pos_x [31:0], pos_y [63:32]; cmd
//  m_axis    out        tvalid tready tdata[31:0]       avg_displacement
//  cfg       in         i_cfg_wen i_cfg_wdata[5:0]      window_count
//
// Requests are taken only while the sequencer waits at idle. A tick request runs the
// bit-serial divide and square root, which share one shift-subtract unit, and drops
// outdated entries; no new request is taken before it ends. Synchronous reset returns the
// sequencer to idle; the distance memory is not cleared. A stalled result waits in the
// output register, and the next tick holds at its emit step only while it is still full.
module windowed_average_displacement #(
    parameter int WINDOW_MAX = wad_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*wad_pkg::COORD_W-1:0]     s_axis_tdata,   // pos_x, pos_y
    input  logic                              s_axis_tuser,   // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wad_pkg::DIST_W-1:0]        m_axis_tdata,   // avg_displacement
    input  logic                              i_cfg_wen,
    input  logic [wad_pkg::WCOUNT_W-1:0]      i_cfg_wdata
);

    localparam int SUMW = wad_pkg::DIST_W + $clog2(WINDOW_MAX);
    localparam int CW   = wad_pkg::COORD_W;

    logic [wad_pkg::STEP_W-1:0]   r_step;
    logic [wad_pkg::STEP_W-1:0]   n_step;
    logic [wad_pkg::CNT_W-1:0]    r_cnt;
    logic [wad_pkg::WCOUNT_W-1:0] r_wcount;
    logic                         r_out_valid;
    logic [wad_pkg::DIST_W-1:0]   r_out_data;

    wad_pkg::t_uword              uw;
    wad_pkg::t_dp_ctl             ctl;
    wad_pkg::t_dp_stat            stat;
    logic [wad_pkg::DIST_W-1:0]   res;
    logic                         in_accept;
    logic                         out_busy;
    logic                         jump;

    assign uw            = wad_pkg::UCODE[r_step];
    assign s_axis_tready = (uw.op == wad_pkg::OP_WAIT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_busy      = r_out_valid && !m_axis_tready;

    always_comb begin
        case (uw.cond)
            wad_pkg::COND_NEVER:    jump = 1'b0;
            wad_pkg::COND_ALWAYS:   jump = 1'b1;
            wad_pkg::COND_NO_TICK:  jump = !(in_accept && (s_axis_tuser == wad_pkg::CMD_TICK));
            wad_pkg::COND_NOT_SEEN: jump = !stat.seen;
            wad_pkg::COND_LOOP:     jump = (r_cnt != wad_pkg::CNT_W'(1));
            wad_pkg::COND_OUT_BUSY: jump = out_busy;
            wad_pkg::COND_NO_DROP:  jump = !stat.drop_needed;
            default:                jump = 1'b0;
        endcase
        n_step = jump ? uw.tgt : r_step + 1'b1;
    end

    always_comb begin
        ctl.op       = uw.op;
        ctl.pos_load = in_accept && (s_axis_tuser == wad_pkg::CMD_POSITION);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= wad_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_wcount    <= wad_pkg::WCOUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            case (uw.cnt)
                wad_pkg::CNT_DIV:  r_cnt <= wad_pkg::CNT_W'(SUMW);
                wad_pkg::CNT_SQRT: r_cnt <= wad_pkg::CNT_W'(wad_pkg::SQRT_STEPS);
                default: begin
                    if (uw.cond == wad_pkg::COND_LOOP) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            endcase
            if (i_cfg_wen) begin
                r_wcount <= i_cfg_wdata;
            end
            // An empty window reports zero instead of the divider's all-ones quotient.
            if (uw.op == wad_pkg::OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
                r_out_data  <= stat.fill_zero ? '0 : res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    wad_dpath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_wcount (r_wcount),
        .i_pos_x  (s_axis_tdata[CW-1:0]),
        .i_pos_y  (s_axis_tdata[2*CW-1:CW]),
        .o_stat   (stat),
        .o_res    (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_loop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.cond == wad_pkg::COND_LOOP) |-> (r_cnt != '0))
        else $error("iteration loop entered with a zero count");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == wad_pkg::CMD_TICK)) |=> (r_step == wad_pkg::ST_AVG))
        else $error("tick request did not start the averaging program");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == wad_pkg::OP_EMIT && !out_busy) |=> m_axis_tvalid)
        else $error("emit step left the result register empty");

endmodule

[bench/tb.sv]
// Self-checking bench for the windowed average displacement block: stream stimulus and checks.
module tb;

    localparam int  WINDOW_MAX    = wad_pkg::WINDOW_MAX_DEF;
    localparam int  SETTLE_CYCLES = 400;
    localparam int  LONG_HOLD     = 1000;
    localparam int  CYCLE_LIMIT   = 2000000;
    localparam int  EXP_DEPTH     = 64;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [2*wad_pkg::COORD_W-1:0]    s_axis_tdata = '0;   // pos_x [31:0], pos_y [63:32]
    logic                             s_axis_tuser = 1'b0; // cmd
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [wad_pkg::DIST_W-1:0]       m_axis_tdata;        // avg_displacement
    logic                             i_cfg_wen = 1'b0;
    logic [wad_pkg::WCOUNT_W-1:0]     i_cfg_wdata = '0;

    windowed_average_displacement #(.WINDOW_MAX(WINDOW_MAX)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Local copy of the block state used to predict each average.
    logic [wad_pkg::DIST_W-1:0]  ring [WINDOW_MAX];
    int                          ring_head;
    int                          ring_fill;
    logic [63:0]                 ring_sum;
    logic [wad_pkg::COORD_W-1:0] cur_x, cur_y, prev_x, prev_y;
    logic                        pos_seen;
    int                          win_count;

    // Expected averages in order; exp_wr and exp_rd count entries written and checked.
    logic [wad_pkg::DIST_W-1:0]  exp_avg [EXP_DEPTH];
    int                          exp_wr = 0;
    int                          exp_rd = 0;
    int                          mismatches = 0;

    // Sender pacing.
    int burst_left = 0;
    bit sender_bursty = 1'b0;

    // Receiver pacing; hold_token is bumped by the main sequence to ask for a long hold.
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    function automatic logic [31:0] floor_sqrt64(input logic [63:0] v);
        logic [63:0] rem, root, bitv;
        rem  = v;
        root = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    function automatic logic [63:0] diff_square(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic [63:0]        m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d < 0)
            d = -d;
        m = {32'b0, d[31:0]};
        return m * m;
    endfunction

    function automatic logic [wad_pkg::DIST_W-1:0] step_distance();
        logic [64:0] total;
        total = {1'b0, diff_square(cur_x, prev_x)} + {1'b0, diff_square(cur_y, prev_y)};
        if (total[64])
            return '1;
        return floor_sqrt64(total[63:0]);
    endfunction

    task automatic reset_tracker();
        ring_head = 0;
        ring_fill = 0;
        ring_sum  = '0;
        cur_x     = '0;
        cur_y     = '0;
        prev_x    = '0;
        prev_y    = '0;
        pos_seen  = 1'b0;
        win_count = int'(wad_pkg::WCOUNT_RST);
    endtask

    // Applies one accepted request to the local state and queues the average it yields.
    task automatic track_motion(input logic cmd, input logic [31:0] px, input logic [31:0] py);
        logic [wad_pkg::DIST_W-1:0] step_len;
        logic [63:0]                mean;
        int                         eff;
        if (cmd == wad_pkg::CMD_POSITION) begin
            cur_x = px;
            cur_y = py;
            if (!pos_seen) begin
                prev_x   = px;
                prev_y   = py;
                pos_seen = 1'b1;
            end
        end else begin
            if (pos_seen) begin
                mean = (ring_fill != 0) ? ring_sum / 64'(ring_fill) : 64'd0;
                exp_avg[exp_wr % EXP_DEPTH] = mean[wad_pkg::DIST_W-1:0];
                exp_wr = exp_wr + 1;
            end
            eff      = (win_count < WINDOW_MAX) ? win_count : WINDOW_MAX;
            step_len = step_distance();
            while (ring_fill > 0 && ring_fill >= eff) begin
                ring_sum  = ring_sum - ring[ring_head];
                ring_head = (ring_head + 1) % WINDOW_MAX;
                ring_fill = ring_fill - 1;
            end
            if (eff > 0) begin
                ring[(ring_head + ring_fill) % WINDOW_MAX] = step_len;
                ring_sum  = ring_sum + step_len;
                ring_fill = ring_fill + 1;
            end
            prev_x = cur_x;
            prev_y = cur_y;
        end
    endtask

    // Offers one request and returns at the edge that accepts it; valid stays high for the next.
    task automatic send_item(input logic cmd, input logic [31:0] px, input logic [31:0] py);
        int gap;
        if (burst_left == 0) begin
            gap = sender_bursty ? $urandom_range(0, 24) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        track_motion(cmd, px, py);
        burst_left = burst_left - 1;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
    endtask

    // A tick before the first position yields no result, so the settle wait covers its tail.
    task automatic program_window(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value[wad_pkg::WCOUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        win_count = value;
    endtask

    task automatic pick_position(output logic [31:0] px, output logic [31:0] py);
        logic [31:0] corners [4];
        int          mode;
        int          r;
        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        mode = $urandom_range(0, 7);
        case (mode)
            0, 1, 2: begin
                r  = 32'h0004_0000;
                px = cur_x + 32'($urandom_range(0, 2 * r) - r);
                py = cur_y + 32'($urandom_range(0, 2 * r) - r);
            end
            3, 4: begin
                px = $urandom;
                py = $urandom;
            end
            5: begin
                px = corners[$urandom_range(0, 3)];
                py = corners[$urandom_range(0, 3)];
            end
            6: begin
                r  = 32'h0100_0000;
                px = cur_x + 32'($urandom_range(0, 2 * r) - r);
                py = cur_y + 32'($urandom_range(0, 2 * r) - r);
            end
            default: begin
                px = cur_x;
                py = cur_y;
            end
        endcase
    endtask

    task automatic test_tick_before_position();
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_extreme_positions();
        send_item(wad_pkg::CMD_POSITION, 32'h8000_0000, 32'h8000_0000);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        // Both axes span the whole range: the distance saturates.
        send_item(wad_pkg::CMD_POSITION, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        // One axis spans the whole range: the largest distance that is still exact.
        send_item(wad_pkg::CMD_POSITION, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_POSITION, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_POSITION, 32'h0003_0000, 32'h0004_0000);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        drain_results();
    endtask

    task automatic test_window_limits();
        // An empty window averages to zero.
        program_window(0);
        send_item(wad_pkg::CMD_POSITION, 32'h0001_0000, 32'h0002_0000);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        // Counts above the maximum are clamped.
        program_window(63);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        // Lowering the count drops the oldest entries on the next tick.
        program_window(1);
        send_item(wad_pkg::CMD_TICK, 32'h0, 32'h0);
        drain_results();
    endtask

    task automatic test_backpressure();
        logic [31:0] px, py;
        int          i;
        program_window(4);
        sender_bursty = 1'b0;
        hold_token <= hold_token + 1;
        for (i = 0; i < 8; i++) begin
            pick_position(px, py);
            send_item(wad_pkg::CMD_POSITION, px, py);
            send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        int          settings [12];
        int          i;
        int          sent;
        int          kind;
        logic [31:0] px, py;
        settings = '{1, 2, 5, 32, 0, 63, 17, 3, 40, 8, 32, 1};
        for (i = 0; i < 12; i++) begin
            program_window(settings[i]);
            sender_bursty = (i % 3 != 0);
            sent = 0;
            while (sent < 115) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    pick_position(px, py);
                    send_item(wad_pkg::CMD_POSITION, px, py);
                    send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
                    sent += 2;
                end else if (kind == 7) begin
                    send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
                    sent += 1;
                end else if (kind == 8) begin
                    pick_position(px, py);
                    send_item(wad_pkg::CMD_POSITION, px, py);
                    pick_position(px, py);
                    send_item(wad_pkg::CMD_POSITION, px, py);
                    send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
                    sent += 3;
                end else begin
                    send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
                    send_item(wad_pkg::CMD_TICK, $urandom, $urandom);
                    sent += 2;
                end
            end
        end
        drain_results();
    endtask

    // Receiver: switches between always ready, random and mostly stalled, plus the long hold.
    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen     <= hold_token;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(32, 400);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Each accepted result is checked against the oldest expected average.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches <= mismatches + 1;
            end else begin
                if (m_axis_tdata !== exp_avg[exp_rd % EXP_DEPTH]) begin
                    $display("%0t: avg_displacement mismatch, expected %h, actual %h",
                             $time, exp_avg[exp_rd % EXP_DEPTH], m_axis_tdata);
                    mismatches <= mismatches + 1;
                end
                exp_rd = exp_rd + 1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        reset_tracker();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tick_before_position();
        test_extreme_positions();
        test_window_limits();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
